// ----- design/tet_pkg.sv -----
// shared types and constants for the tagged entry table
package tet_pkg;

	localparam int DEPTH_DEF         = 16;
	localparam int PAYLOAD_WIDTH_DEF = 64;
	localparam int TAG_WIDTH_DEF     = 16;

	localparam int REQ_W     = 2;
	localparam int KEY_W     = 16;
	localparam int PAY_W     = 64;
	localparam int STATUS_W  = 2;

	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_GET    = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} tet_state_t;

	typedef struct packed {
		logic cap;
		logic rem;
		logic add;
	} tet_ctrl_t;

endpackage

// ----- design/tagged_entry_table.sv -----
// top level of the tagged entry table: request control and the cell chain
//
// Request words enter on in_valid/in_ready with req_type, key_tag, key_valid
// and payload; each request gives exactly one result word on
// out_valid/out_ready with status, result_tag and result_payload.
// Add stores the payload under the running tag counter unless the key
// matches a stored tag (duplicate) or the table is full. Remove deletes the
// oldest matching entry and the later cells shift down by one. Get returns
// the oldest matching entry.
// Every cell compares its tag at the accepting edge and registers its match
// flag; the table is updated and the result registered later, at the edge
// where the request commits in ST_LOOK, once the output register is free.
// The block takes one request at a time; in_ready is low while a request is
// in the chain. If the receiver stalls, the result waits in the output
// register and a request in the chain holds until the register frees.
// Reset empties the table and clears the tag counter; it takes effect at once.
module tagged_entry_table #(
	parameter int DEPTH         = tet_pkg::DEPTH_DEF,
	parameter int PAYLOAD_WIDTH = tet_pkg::PAYLOAD_WIDTH_DEF,
	parameter int TAG_WIDTH     = tet_pkg::TAG_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tet_pkg::REQ_W-1:0]     req_type,
	input  logic [tet_pkg::KEY_W-1:0]     key_tag,
	input  logic                          key_valid,
	input  logic [tet_pkg::PAY_W-1:0]     payload,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tet_pkg::STATUS_W-1:0]  status,
	output logic [tet_pkg::KEY_W-1:0]     result_tag,
	output logic [tet_pkg::PAY_W-1:0]     result_payload
);
	import tet_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	tet_state_t state_q, state_nxt;

	logic [REQ_W-1:0]         req_q;
	logic [PAYLOAD_WIDTH-1:0] inpay_q;
	logic [CNT_W-1:0]         count_q;
	logic [TAG_WIDTH-1:0]     tagctr_q;

	logic [STATUS_W-1:0]      status_q;
	logic [KEY_W-1:0]         rtag_q;
	logic [PAY_W-1:0]         rpay_q;
	logic                     out_valid_q;

	logic accept;
	logic out_free;
	logic commit;
	logic found;
	logic full;
	tet_ctrl_t ctrl;

	logic [TAG_WIDTH-1:0]     key_ext;
	logic [TAG_WIDTH-1:0]     cell_tag [DEPTH];
	logic [PAYLOAD_WIDTH-1:0] cell_pay [DEPTH];
	logic [DEPTH-1:0]         cell_first;
	logic [DEPTH:0]           below;
	logic [TAG_WIDTH-1:0]     sel_tag;
	logic [PAYLOAD_WIDTH-1:0] sel_pay;

	logic [STATUS_W-1:0]      st_d;
	logic [KEY_W-1:0]         rtag_d;
	logic [PAY_W-1:0]         rpay_d;

	assign key_ext  = TAG_WIDTH'(key_tag);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign full     = count_q == CNT_W'(DEPTH);
	assign found    = below[DEPTH];
	assign below[0] = 1'b0;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_LOOK;
			end
			ST_LOOK: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_LOOK: commit   = out_free;
			default: begin
				in_ready = 1'b0;
				commit   = 1'b0;
			end
		endcase
	end

	assign ctrl.cap = accept;
	assign ctrl.rem = commit && (req_q == REQ_REMOVE) && found;
	assign ctrl.add = commit && (req_q == REQ_ADD) && !found && !full;

	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			logic [TAG_WIDTH-1:0]     nt;
			logic [PAYLOAD_WIDTH-1:0] np;
			if (i + 1 < DEPTH) begin : g_mid
				assign nt = cell_tag[i+1];
				assign np = cell_pay[i+1];
			end else begin : g_end
				assign nt = cell_tag[i];
				assign np = cell_pay[i];
			end
			tet_cell #(
				.IDX          (i),
				.CNT_W        (CNT_W),
				.PAYLOAD_WIDTH(PAYLOAD_WIDTH),
				.TAG_WIDTH    (TAG_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.count    (count_q),
				.key      (key_ext),
				.key_valid(key_valid),
				.new_tag  (tagctr_q),
				.new_pay  (inpay_q),
				.nxt_tag  (nt),
				.nxt_pay  (np),
				.below_in (below[i]),
				.below_out(below[i+1]),
				.tag      (cell_tag[i]),
				.pay      (cell_pay[i]),
				.first    (cell_first[i])
			);
		end
	endgenerate

	// one-hot select of the oldest match
	always_comb begin
		sel_tag = '0;
		sel_pay = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_first[i]) begin
				sel_tag = sel_tag | cell_tag[i];
				sel_pay = sel_pay | cell_pay[i];
			end
		end
	end

	always_comb begin
		st_d   = STATUS_MISS;
		rtag_d = '0;
		rpay_d = '0;
		case (req_q)
			REQ_ADD: begin
				if (found) begin
					rtag_d = KEY_W'(sel_tag);
				end else if (full) begin
					st_d = STATUS_FULL;
				end else begin
					st_d   = STATUS_OK;
					rtag_d = KEY_W'(tagctr_q);
				end
			end
			REQ_REMOVE: begin
				if (found) begin
					st_d   = STATUS_OK;
					rtag_d = KEY_W'(sel_tag);
				end
			end
			REQ_GET: begin
				if (found) begin
					st_d   = STATUS_OK;
					rtag_d = KEY_W'(sel_tag);
					rpay_d = PAY_W'(sel_pay);
				end
			end
			default: st_d = STATUS_MISS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			tagctr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.add) begin
				count_q  <= count_q + 1'b1;
				tagctr_q <= tagctr_q + 1'b1;
			end else if (ctrl.rem) begin
				count_q <= count_q - 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type;
			inpay_q <= PAYLOAD_WIDTH'(payload);
		end
		if (commit) begin
			status_q <= st_d;
			rtag_q   <= rtag_d;
			rpay_q   <= rpay_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_tag     = rtag_q;
	assign result_payload = rpay_q;

endmodule

// ----- design/tet_cell.sv -----
// one table cell: stored tag and payload, match flag and shift from neighbor
module tet_cell #(
	parameter int IDX           = 0,
	parameter int CNT_W         = 5,
	parameter int PAYLOAD_WIDTH = 64,
	parameter int TAG_WIDTH     = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tet_pkg::tet_ctrl_t       ctrl,
	input  logic [CNT_W-1:0]         count,
	input  logic [TAG_WIDTH-1:0]     key,
	input  logic                     key_valid,
	input  logic [TAG_WIDTH-1:0]     new_tag,
	input  logic [PAYLOAD_WIDTH-1:0] new_pay,
	input  logic [TAG_WIDTH-1:0]     nxt_tag,
	input  logic [PAYLOAD_WIDTH-1:0] nxt_pay,
	input  logic                     below_in,
	output logic                     below_out,
	output logic [TAG_WIDTH-1:0]     tag,
	output logic [PAYLOAD_WIDTH-1:0] pay,
	output logic                     first
);
	import tet_pkg::*;

	logic [TAG_WIDTH-1:0]     tag_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic                     hit_q;
	logic                     occupied;
	logic                     load;

	assign occupied  = CNT_W'(IDX) < count;
	assign load      = ctrl.add && (count == CNT_W'(IDX));
	assign below_out = below_in | hit_q;
	assign first     = hit_q & ~below_in;
	assign tag       = tag_q;
	assign pay       = pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.cap) begin
			hit_q <= occupied && key_valid && (tag_q == key);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q <= new_tag;
			pay_q <= new_pay;
		end else if (ctrl.rem && below_out) begin
			tag_q <= nxt_tag;
			pay_q <= nxt_pay;
		end
	end

endmodule

// ----- sim/tb.sv -----
// self-checking testbench for the tagged entry table with a table model, directed requests and random word traffic
`timescale 1ns / 100ps

module tb;
	import tet_pkg::*;

	localparam int DEPTH = tet_pkg::DEPTH_DEF;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 1000;

	typedef struct {
		bit [REQ_W-1:0]    kind;
		bit [KEY_W-1:0]    key;
		bit                key_ok;
		bit [PAY_W-1:0]    data;
		int                gap;
		int                stall;
		bit                drain;
		bit [STATUS_W-1:0] exp_status;
		bit [KEY_W-1:0]    exp_tag;
		bit [PAY_W-1:0]    exp_data;
	} table_op_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = '0;
	logic [KEY_W-1:0] key_tag = '0;
	logic key_valid = 1'b0;
	logic [PAY_W-1:0] payload = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0] result_tag;
	logic [PAY_W-1:0] result_payload;

	bit [KEY_W-1:0] tbl_tag [DEPTH];
	bit [PAY_W-1:0] tbl_data [DEPTH];
	int tbl_count;
	bit [KEY_W-1:0] model_tag;

	table_op_t pending_ops[$];
	table_op_t expected_results[$];
	table_op_t nxt, cur, got;
	bit armed;
	bit idle_on;
	bit hold_next;
	int rx_wait;
	int mismatches;
	int quiet_cycles;

	tagged_entry_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.key_tag(key_tag),
		.key_valid(key_valid),
		.payload(payload),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.result_tag(result_tag),
		.result_payload(result_payload)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic table_op_t apply_to_table(table_op_t w);
		int hit;
		int i;
		hit = -1;
		if (w.key_ok) begin
			for (i = 0; i < tbl_count; i++)
				if (hit < 0 && tbl_tag[i] == w.key)
					hit = i;
		end
		w.exp_status = STATUS_MISS;
		w.exp_tag = '0;
		w.exp_data = '0;
		case (w.kind)
			REQ_ADD: begin
				if (hit >= 0) begin
					w.exp_tag = tbl_tag[hit];
				end else if (tbl_count >= DEPTH) begin
					w.exp_status = STATUS_FULL;
				end else begin
					tbl_tag[tbl_count] = model_tag;
					tbl_data[tbl_count] = w.data;
					tbl_count++;
					w.exp_tag = model_tag;
					model_tag = model_tag + 1'b1;
					w.exp_status = STATUS_OK;
				end
			end
			REQ_REMOVE: begin
				if (hit >= 0) begin
					w.exp_tag = tbl_tag[hit];
					for (i = hit; i < tbl_count - 1; i++) begin
						tbl_tag[i] = tbl_tag[i + 1];
						tbl_data[i] = tbl_data[i + 1];
					end
					tbl_count--;
					w.exp_status = STATUS_OK;
				end
			end
			REQ_GET: begin
				if (hit >= 0) begin
					w.exp_tag = tbl_tag[hit];
					w.exp_data = tbl_data[hit];
					w.exp_status = STATUS_OK;
				end
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic send(input bit [REQ_W-1:0] kind, input bit [KEY_W-1:0] key,
		input bit key_ok, input bit [PAY_W-1:0] data);
		table_op_t w;
		w.kind = kind;
		w.key = key;
		w.key_ok = key_ok;
		w.data = data;
		w.gap = idle_on ? $urandom_range(0, 4) : 0;
		w.stall = idle_on ? $urandom_range(0, 4) : 0;
		w.drain = hold_next;
		hold_next = 1'b0;
		pending_ops.push_back(apply_to_table(w));
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			armed = 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(cur);
			if (!in_valid || in_ready) begin
				if (!armed && pending_ops.size() > 0) begin
					nxt = pending_ops.pop_front();
					armed = 1'b1;
				end
				if (armed && nxt.gap == 0 && (!nxt.drain || expected_results.size() == 0)) begin
					req_type <= nxt.kind;
					key_tag <= nxt.key;
					key_valid <= nxt.key_ok;
					payload <= nxt.data;
					in_valid <= 1'b1;
					cur = nxt;
					armed = 1'b0;
				end else begin
					in_valid <= 1'b0;
					if (armed && nxt.gap > 0)
						nxt.gap--;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = -1;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: status %0d tag %h payload %h",
							status, result_tag, result_payload);
				end else begin
					got = expected_results.pop_front();
					if (status !== got.exp_status || result_tag !== got.exp_tag ||
						result_payload !== got.exp_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch op %0d key %h/%0d: exp %0d %h %h got %0d %h %h",
								got.kind, got.key, got.key_ok, got.exp_status, got.exp_tag,
								got.exp_data, status, result_tag, result_payload);
					end
				end
				rx_wait = -1;
			end
			if (rx_wait < 0 && expected_results.size() > 0)
				rx_wait = expected_results[0].stall;
			if (out_valid && rx_wait > 0)
				rx_wait--;
			out_ready <= (rx_wait == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		int n;
		int r;
		int add_share;
		bit [KEY_W-1:0] key;
		bit [PAY_W-1:0] data;
		bit [REQ_W-1:0] kind;

		tbl_count = 0;
		model_tag = '0;
		mismatches = 0;
		quiet_cycles = 0;
		hold_next = 1'b0;
		idle_on = 1'b1;

		// directed: empty table, bad code, duplicates, invalid key, shift, full
		send(REQ_GET, 16'h0000, 1'b1, '0);
		send(REQ_REMOVE, 16'h0000, 1'b1, '0);
		send(REQ_UNUSED, 16'hFFFF, 1'b1, '1);
		send(REQ_ADD, 16'hFFFF, 1'b0, '0);
		send(REQ_ADD, 16'hFFFF, 1'b1, '1);
		send(REQ_ADD, 16'h0000, 1'b1, {$urandom, $urandom});
		send(REQ_GET, 16'h0001, 1'b1, '0);
		send(REQ_GET, 16'h0000, 1'b0, '0);
		send(REQ_REMOVE, 16'h0000, 1'b1, '1);
		send(REQ_GET, 16'h0001, 1'b1, '0);
		for (n = 0; n < DEPTH - 1; n++)
			send(REQ_ADD, 16'(n), 1'b0, {$urandom, $urandom});
		send(REQ_ADD, 16'h0005, 1'b1, '1);
		send(REQ_ADD, 16'h0005, 1'b0, '1);

		// random traffic
		hold_next = 1'b1;
		for (n = 0; n < 1225; n++) begin
			if (n % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) == 0)
				hold_next = 1'b1;
			add_share = (tbl_count < 10) ? 50 : 38;
			r = $urandom_range(0, 99);
			if (r < add_share)
				kind = REQ_ADD;
			else if (r < 68)
				kind = REQ_REMOVE;
			else if (r < 96)
				kind = REQ_GET;
			else
				kind = REQ_UNUSED;
			r = $urandom_range(0, 9);
			if (tbl_count > 0 && r < ((kind == REQ_ADD) ? 3 : 6))
				key = tbl_tag[$urandom_range(0, tbl_count - 1)];
			else if (r < 8)
				key = model_tag - 16'($urandom_range(0, 20));
			else
				key = 16'($urandom);
			r = $urandom_range(0, 9);
			if (r == 0)
				data = '0;
			else if (r == 1)
				data = '1;
			else
				data = {$urandom, $urandom};
			send(kind, key, ($urandom_range(0, 9) != 0), data);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || armed || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- tagged_entry_table.f -----
design/tet_pkg.sv
design/tet_cell.sv
design/tagged_entry_table.sv
sim/tb.sv
